@@ rtl/smf_pkg.sv @@
package smf_pkg;

  // Fixed widths of the request and result fields.
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 4;
  localparam logic [COUNT_W-1:0] COUNT_SAT = 4'd15;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic in_ready;   // take input requests and store them
    logic start;      // set complete: clear position counter and best tracker
    logic fetch;      // read the value at position i
    logic hold;       // latch value i, clear count and j
    logic scan;       // read position j and compare against value i
    logic tail;       // fold the last compare in and update the best tracker
    logic next_i;     // step to the next position i
    logic load_out;   // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_acc;   // a request marked last was accepted this cycle
    logic j_last;     // j is at the last stored position
    logic i_last;     // i is at the last stored position
    logic out_free;   // output register can take a new result
  } sts_t;

endpackage

@@ rtl/smf_if.sv @@
// Input channel: one set element per request.
interface smf_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [smf_pkg::VALUE_W-1:0]  value;
  logic                                last_item;

  modport source (output valid, output value, output last_item, input ready);
  modport sink   (input valid, input value, input last_item, output ready);
endinterface

// Result channel: one result per completed set.
interface smf_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [smf_pkg::VALUE_W-1:0]  mode_value;
  logic                                has_mode;
  logic        [smf_pkg::COUNT_W-1:0]  mode_count;
  logic                                overflowed;

  modport source (output valid, output mode_value, output has_mode, output mode_count,
                  output overflowed, input ready);
  modport sink   (input valid, input mode_value, input has_mode, input mode_count,
                  input overflowed, output ready);
endinterface

@@ rtl/smf_ctrl.sv @@
module smf_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  smf_pkg::sts_t sts,
  output smf_pkg::cmd_t cmd
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_FETCH  = 6'b000010,
    ST_HOLD   = 6'b000100,
    ST_SCAN   = 6'b001000,
    ST_TAIL   = 6'b010000,
    ST_RESULT = 6'b100000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.last_acc) begin
          cmd.start = 1'b1;
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = ST_HOLD;
      end
      ST_HOLD: begin
        cmd.hold  = 1'b1;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.j_last) begin
          state_nxt = ST_TAIL;
        end
      end
      ST_TAIL: begin
        cmd.tail = 1'b1;
        if (sts.i_last) begin
          state_nxt = ST_RESULT;
        end else begin
          cmd.next_i = 1'b1;
          state_nxt  = ST_FETCH;
        end
      end
      ST_RESULT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/smf_dp.sv @@
module smf_dp #(
  parameter int MAX_ITEMS = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  smf_pkg::cmd_t cmd,
  output smf_pkg::sts_t sts,
  smf_in_if.sink        in_ch,
  smf_out_if.source     out_ch
);

  localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int EXT_W = CNT_W + smf_pkg::COUNT_W;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ITEMS);

  // Value store, one write port and one registered read port.
  logic [smf_pkg::VALUE_W-1:0] mem [MAX_ITEMS];
  logic [smf_pkg::VALUE_W-1:0] rd_data_r;
  logic [IDX_W-1:0]            rd_addr;

  logic [CNT_W-1:0]            n_r;
  logic                        ovf_r;
  logic [IDX_W-1:0]            i_r;
  logic [IDX_W-1:0]            j_r;
  logic [smf_pkg::VALUE_W-1:0] vi_r;
  logic [CNT_W-1:0]            cnt_r;
  logic                        cmp_en_r;
  logic [CNT_W-1:0]            best_cnt_r;
  logic [smf_pkg::VALUE_W-1:0] best_val_r;
  logic                        uniq_r;

  logic                                 out_valid_r;
  logic signed [smf_pkg::VALUE_W-1:0]   out_value_r;
  logic                                 out_has_r;
  logic        [smf_pkg::COUNT_W-1:0]   out_count_r;
  logic                                 out_ovf_r;

  logic             accept;
  logic             not_full;
  logic [CNT_W-1:0] n_m1;
  logic             match;
  logic [CNT_W-1:0] cnt_fin;
  logic [EXT_W-1:0] best_ext;
  logic [smf_pkg::COUNT_W-1:0] cnt_sat;

  assign accept   = in_ch.valid && cmd.in_ready;
  assign not_full = (n_r < MAX_CNT);
  assign n_m1     = n_r - CNT_W'(1);
  assign match    = cmp_en_r && (rd_data_r == vi_r);
  assign cnt_fin  = cnt_r + CNT_W'(match);
  assign rd_addr  = cmd.fetch ? i_r : j_r;

  assign in_ch.ready = cmd.in_ready;

  // Status back to the controller.
  assign sts.last_acc = accept && in_ch.last_item;
  assign sts.j_last   = (CNT_W'(j_r) == n_m1);
  assign sts.i_last   = (CNT_W'(i_r) == n_m1);
  assign sts.out_free = !out_valid_r || out_ch.ready;

  // Store write and registered read.
  always_ff @(posedge clk) begin
    if (accept && not_full) begin
      mem[n_r[IDX_W-1:0]] <= in_ch.value;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Fill count and overflow flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r   <= '0;
      ovf_r <= 1'b0;
    end else if (cmd.load_out) begin
      n_r   <= '0;
      ovf_r <= 1'b0;
    end else if (accept) begin
      if (not_full) begin
        n_r <= n_r + CNT_W'(1);
      end else begin
        ovf_r <= 1'b1;
      end
    end
  end

  // Position counters and compare pipeline flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r      <= '0;
      j_r      <= '0;
      cmp_en_r <= 1'b0;
    end else begin
      cmp_en_r <= cmd.scan;
      if (cmd.start) begin
        i_r <= '0;
      end else if (cmd.next_i) begin
        i_r <= i_r + IDX_W'(1);
      end
      if (cmd.hold) begin
        j_r <= '0;
      end else if (cmd.scan) begin
        j_r <= j_r + IDX_W'(1);
      end
    end
  end

  // Count of matches for the current position.
  always_ff @(posedge clk) begin
    if (cmd.hold) begin
      vi_r  <= rd_data_r;
      cnt_r <= '0;
    end else if (cmd.scan) begin
      cnt_r <= cnt_fin;
    end
  end

  // Running best: earliest highest count; the unique flag clears on a tie with another value.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      best_cnt_r <= '0;
      best_val_r <= '0;
      uniq_r     <= 1'b1;
    end else if (cmd.tail) begin
      if (cnt_fin > best_cnt_r) begin
        best_cnt_r <= cnt_fin;
        best_val_r <= vi_r;
        uniq_r     <= 1'b1;
      end else if ((cnt_fin == best_cnt_r) && (vi_r != best_val_r)) begin
        uniq_r <= 1'b0;
      end
    end
  end

  // Saturate the count to the result field width.
  assign best_ext = EXT_W'(best_cnt_r);
  assign cnt_sat  = (best_ext > EXT_W'(smf_pkg::COUNT_SAT)) ? smf_pkg::COUNT_SAT
                                                              : best_ext[smf_pkg::COUNT_W-1:0];

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_value_r <= uniq_r ? best_val_r : '0;
      out_has_r   <= uniq_r;
      out_count_r <= cnt_sat;
      out_ovf_r   <= ovf_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.mode_value = out_value_r;
  assign out_ch.has_mode   = out_has_r;
  assign out_ch.mode_count = out_count_r;
  assign out_ch.overflowed = out_ovf_r;

`ifndef NO_ASSERTIONS
  // The fill count never passes the store depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= MAX_CNT)
    else $error("fill count exceeds store depth");

  // A request that finds the store full marks the set as overflowed.
  a_ovf_set: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !not_full && !cmd.load_out) |=> ovf_r)
    else $error("dropped request did not set overflow");

  // Loading a result empties the store and presents the result.
  a_load_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> (n_r == '0) && out_valid_r && !ovf_r)
    else $error("result load did not clear the set");

  // A result is loaded only when the output register can take it.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ch.ready))
    else $error("result overwrote a pending one");
`endif

endmodule

@@ rtl/set_mode_finder.sv @@
// Set mode finder.
// The input channel carries one signed 32-bit element per request; a request
// with last_item set closes the set. Up to MAX_ITEMS elements are stored;
// further requests are dropped and flag overflowed in that set's result.
// After the last request is accepted, the block counts matches for every
// stored position against all stored positions, one stored-value read per
// cycle through a single registered read port. Input is not taken during
// that counting phase, nor while a second result waits; otherwise a
// request is taken every cycle.
// The result channel carries the mode value, has_mode, the highest count
// (saturated at 15) and overflowed. Ties between different values give
// has_mode low and mode_value zero. The result sits in an output register,
// so a new set can be loaded while the receiver stalls; a second result
// waits in the controller until that register is taken.
// Reset (synchronous, active low) empties the store, clears the overflow
// flag and drops any pending result.
module set_mode_finder #(
  parameter int MAX_ITEMS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  smf_in_if.sink    in_ch,
  smf_out_if.source out_ch
);

  smf_pkg::cmd_t cmd;
  smf_pkg::sts_t sts;

  // Sequencer.
  smf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Store, counters and result register.
  smf_dp #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .sts    (sts),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule
